// ===== src/gcomp_pkg.sv =====
// ============================================================================
// gcomp_pkg
// Shared types, codes and arithmetic helpers for the glyph coverage
// compositor.
// ============================================================================
`default_nettype none

package gcomp_pkg;

    // Item kinds.
    localparam logic KIND_FILL  = 1'b0;
    localparam logic KIND_GLYPH = 1'b1;

    // Width of one colour channel and number of channels in a pixel.
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;

    // Full-scale channel value.
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    // Command word: one pixel to composite.
    typedef struct packed {
        logic        kind;
        logic [31:0] color;
        logic [7:0]  coverage;
        logic [31:0] dest_pixel;
    } gcomp_cmd_t;

    // Result word: the new pixel and its store flag.
    typedef struct packed {
        logic [31:0] pixel;
        logic        write_enable;
    } gcomp_res_t;

    // Product of two channels, divided by 255 and truncated.
    // The quotient is first estimated as the high byte; the remainder
    // estimate is then below 510, so a single correction step is exact.
    function automatic logic [CHAN_W-1:0] mul_div255(
        input logic [CHAN_W-1:0] x,
        input logic [CHAN_W-1:0] y
    );
        logic [2*CHAN_W-1:0] p;
        logic [CHAN_W:0]     r;
        p = {{CHAN_W{1'b0}}, x} * {{CHAN_W{1'b0}}, y};
        r = {1'b0, p[CHAN_W-1:0]} + {1'b0, p[2*CHAN_W-1:CHAN_W]};
        if (r >= {1'b0, CHAN_MAX})
        begin
            return p[2*CHAN_W-1:CHAN_W] + {{(CHAN_W-1){1'b0}}, 1'b1};
        end
        return p[2*CHAN_W-1:CHAN_W];
    endfunction

    // Channel sum that saturates at full scale.
    function automatic logic [CHAN_W-1:0] sat_add(
        input logic [CHAN_W-1:0] s,
        input logic [CHAN_W-1:0] d
    );
        logic [CHAN_W:0] v;
        v = {1'b0, s} + {1'b0, d};
        if (v[CHAN_W])
        begin
            return CHAN_MAX;
        end
        return v[CHAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/glyph_coverage_compositor.sv =====
// ============================================================================
// glyph_coverage_compositor
// Per-pixel text compositor for premultiplied ARGB8888: background fills
// and source-over blending of glyph coverage samples.
// ============================================================================
//
//  Channel   Ports                  Handshake
//  --------  ---------------------  ------------------------------------------
//  command   command                taken when start is high and busy is low
//  result    result                 valid for one cycle while done is high
//
//  One word enters per clock; its result appears on result with done high
//  once it has passed three register stages: premultiply, coverage
//  scaling, and destination fade with the lane sum.
//  busy is never raised, as every stage advances on every clock.
//  The receiver cannot stall; results are not held.
//  Reset clears the stage valid bits, so no result appears after reset
//  until a new word is taken.
//
`default_nettype none

module glyph_coverage_compositor
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  gcomp_pkg::gcomp_cmd_t command,
    output logic                  done,
    output gcomp_pkg::gcomp_res_t result
);

    localparam int CW = gcomp_pkg::CHAN_W;
    localparam int NC = gcomp_pkg::NUM_CHAN;

    // Stage valid bits.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic done_reg;

    // Stage one payload.
    logic           s1_kind_reg;
    logic [CW-1:0]  s1_cov_reg;
    logic [31:0]    s1_dst_reg;
    logic [31:0]    s1_pm_reg;
    logic [31:0]    s1_pm_next;

    // Stage two payload.
    logic           s2_kind_reg;
    logic           s2_cov_zero_reg;
    logic [31:0]    s2_dst_reg;
    logic [31:0]    s2_pm_reg;
    logic [31:0]    s2_src_reg;
    logic [31:0]    s2_src_next;

    // Stage three (output) payload.
    gcomp_pkg::gcomp_res_t result_reg;
    gcomp_pkg::gcomp_res_t result_next;
    logic [CW-1:0]         inv_alpha;
    logic [2*CW-1:0]       fade_prod [NC];
    logic [31:0]           over_pix;

    logic accept;

    // The pipeline never stalls.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    // Stage one: premultiply the colour by its own alpha.
    always_comb
    begin
        s1_pm_next[31:24] = command.color[31:24];
        for (int i = 0; i < NC - 1; i++)
        begin
            s1_pm_next[i*CW +: CW] =
                gcomp_pkg::mul_div255(command.color[i*CW +: CW], command.color[31:24]);
        end
    end

    // Stage two: scale all four premultiplied channels by the coverage.
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            s2_src_next[i*CW +: CW] =
                gcomp_pkg::mul_div255(s1_pm_reg[i*CW +: CW], s1_cov_reg);
        end
    end

    // Stage three: fade the destination by the inverse source alpha, add
    // the source in separate lanes and pick the word's result.
    always_comb
    begin
        inv_alpha = gcomp_pkg::CHAN_MAX - s2_src_reg[31:24];
        for (int i = 0; i < NC; i++)
        begin
            fade_prod[i] = {{CW{1'b0}}, s2_dst_reg[i*CW +: CW]} * {{CW{1'b0}}, inv_alpha};
            over_pix[i*CW +: CW] =
                gcomp_pkg::sat_add(s2_src_reg[i*CW +: CW], fade_prod[i][2*CW-1:CW]);
        end

        if (s2_kind_reg == gcomp_pkg::KIND_FILL)
        begin
            result_next.pixel        = s2_pm_reg;
            result_next.write_enable = 1'b1;
        end
        else if (s2_cov_zero_reg)
        begin
            result_next.pixel        = s2_dst_reg;
            result_next.write_enable = 1'b0;
        end
        else
        begin
            result_next.pixel        = over_pix;
            result_next.write_enable = 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_kind_reg     <= command.kind;
        s1_cov_reg      <= command.coverage;
        s1_dst_reg      <= command.dest_pixel;
        s1_pm_reg       <= s1_pm_next;

        s2_kind_reg     <= s1_kind_reg;
        s2_cov_zero_reg <= (s1_cov_reg == '0);
        s2_dst_reg      <= s1_dst_reg;
        s2_pm_reg       <= s1_pm_reg;
        s2_src_reg      <= s2_src_next;

        result_reg      <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every word taken gives a result with done high.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("taken word gave no result after three cycles");

    // No result without a matching word taken before it.
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a matching word");

    // A withheld store passes the destination pixel through untouched.
    a_skip_keeps_dest: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.write_enable) |-> (result.pixel == $past(command.dest_pixel, 3)))
        else $error("skipped pixel differs from the destination");

    // A fill always stores.
    a_fill_stores: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(command.kind, 3) == gcomp_pkg::KIND_FILL)) |-> result.write_enable)
        else $error("fill word did not store");

endmodule

`default_nettype wire
